// ===== hw/rtl/cbsg_pkg.sv =====
// Shared constants, control-word type and microprogram for the cubic Bezier
// segment generator. No dependencies; every other file imports this package.
package cbsg_pkg;

    localparam int STEPS     = 1024;
    localparam int STEPS_LOG = $clog2(STEPS);
    localparam int IDX_W     = STEPS_LOG + 1;
    localparam int COORD_W   = 12;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(NUM_CFG);
    localparam int TMP_W     = 2 * STEPS_LOG + 1;
    localparam int WGT_W     = 3 * STEPS_LOG + 1;
    localparam int OPB_W     = (STEPS_LOG + 3 > COORD_W) ? STEPS_LOG + 3 : COORD_W;
    localparam int PROD_W    = WGT_W + 1 + OPB_W;
    localparam int ACC_W     = 3 * STEPS_LOG + COORD_W + 1;
    localparam int SHIFT     = 3 * STEPS_LOG;
    localparam int PC_W      = 4;

    // Configuration register indexes.
    localparam logic [CFG_SEL_W-1:0] CFG_P0_X = 3'd0;
    localparam logic [CFG_SEL_W-1:0] CFG_P0_Y = 3'd1;
    localparam logic [CFG_SEL_W-1:0] CFG_P1_X = 3'd2;
    localparam logic [CFG_SEL_W-1:0] CFG_P1_Y = 3'd3;
    localparam logic [CFG_SEL_W-1:0] CFG_P2_X = 3'd4;
    localparam logic [CFG_SEL_W-1:0] CFG_P2_Y = 3'd5;
    localparam logic [CFG_SEL_W-1:0] CFG_P3_X = 3'd6;
    localparam logic [CFG_SEL_W-1:0] CFG_P3_Y = 3'd7;

    // Multiplier operand A sources.
    localparam logic [2:0] OA_SELF = 3'd0;
    localparam logic [2:0] OA_TEMP = 3'd1;
    localparam logic [2:0] OA_W0   = 3'd2;
    localparam logic [2:0] OA_W1   = 3'd3;
    localparam logic [2:0] OA_W2   = 3'd4;
    localparam logic [2:0] OA_W3   = 3'd5;

    // Multiplier operand B sources.
    localparam logic [2:0] OB_SELF   = 3'd0;
    localparam logic [2:0] OB_3OTHER = 3'd1;
    localparam logic [2:0] OB_C0     = 3'd2;
    localparam logic [2:0] OB_C1     = 3'd3;
    localparam logic [2:0] OB_C2     = 3'd4;
    localparam logic [2:0] OB_C3     = 3'd5;

    // Product destinations.
    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_TEMP = 3'd1;
    localparam logic [2:0] DST_WEND = 3'd2;
    localparam logic [2:0] DST_WMID = 3'd3;
    localparam logic [2:0] DST_PROD = 3'd4;

    // Accumulator operations.
    localparam logic [1:0] ACC_NOP  = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // Jump conditions.
    localparam logic [1:0] CC_NONE     = 2'd0;
    localparam logic [1:0] CC_NO_ITEM  = 2'd1;
    localparam logic [1:0] CC_OUT_FULL = 2'd2;

    // Named program steps.
    localparam logic [PC_W-1:0] ST_IDLE = 4'd0;
    localparam logic [PC_W-1:0] ST_EMIT = 4'd9;

    typedef struct packed {
        logic [2:0]      op_a;
        logic [2:0]      op_b;
        logic [2:0]      dst;
        logic [1:0]      acc;
        logic            wait_in;
        logic            emit;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
        logic            wrap;
    } ucw_t;

    typedef struct packed {
        logic ready;
        logic emit;
    } seq_stat_t;

    // The microprogram. Lane X uses a as its own step weight and b as the
    // other; lane Y the reverse, so between them the lanes build all four Bernstein weights.
    function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
        ucw_t w;
        begin
            case (pc)
                //          op_a     op_b       dst       acc       in    emit  cond         target   wrap
                4'd0: w = '{OA_SELF, OB_SELF,   DST_NONE, ACC_NOP,  1'b1, 1'b0, CC_NO_ITEM,  ST_IDLE, 1'b0};
                4'd1: w = '{OA_SELF, OB_SELF,   DST_TEMP, ACC_NOP,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd2: w = '{OA_TEMP, OB_SELF,   DST_WEND, ACC_NOP,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd3: w = '{OA_TEMP, OB_3OTHER, DST_WMID, ACC_NOP,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd4: w = '{OA_W0,   OB_C0,     DST_PROD, ACC_NOP,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd5: w = '{OA_W1,   OB_C1,     DST_PROD, ACC_LOAD, 1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd6: w = '{OA_W2,   OB_C2,     DST_PROD, ACC_ADD,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd7: w = '{OA_W3,   OB_C3,     DST_PROD, ACC_ADD,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd8: w = '{OA_SELF, OB_SELF,   DST_NONE, ACC_ADD,  1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b0};
                4'd9: w = '{OA_SELF, OB_SELF,   DST_NONE, ACC_NOP,  1'b0, 1'b1, CC_OUT_FULL, ST_EMIT, 1'b1};
                default: w = '{OA_SELF, OB_SELF, DST_NONE, ACC_NOP, 1'b0, 1'b0, CC_NONE,     ST_IDLE, 1'b1};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== hw/rtl/cbsg_sequencer.sv =====
// Step counter and control-store lookup for the Bezier segment generator.
// Depends on cbsg_pkg for the control word and the microprogram.
module cbsg_sequencer import cbsg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      out_busy,
    output ucw_t      cw,
    output seq_stat_t stat
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign cw = ucode_rom(pc_reg);

    always_comb begin
        case (cw.cond)
            CC_NO_ITEM:  jump = ~in_valid;
            CC_OUT_FULL: jump = out_busy;
            default:     jump = 1'b0;
        endcase
        if (jump) begin
            pc_next = cw.target;
        end else if (cw.wrap) begin
            pc_next = ST_IDLE;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    assign stat.ready = cw.wait_in;
    assign stat.emit  = cw.emit & ~out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/cbsg_datapath.sv =====
// Two multiply-accumulate lanes (x and y) with shared Bernstein weight
// registers, driven by the control word. Depends on cbsg_pkg.
module cbsg_datapath import cbsg_pkg::*; (
    input  logic                      aclk,
    input  ucw_t                      cw,
    input  logic [IDX_W-1:0]          a_val,
    input  logic [IDX_W-1:0]          b_val,
    input  logic signed [COORD_W-1:0] coord [2][4],
    output logic signed [COORD_W-1:0] res [2]
);

    localparam logic signed [ACC_W-1:0] RND_BIAS =
        {{(ACC_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};

    logic [TMP_W-1:0]          temp_reg [2];
    logic [WGT_W-1:0]          w_reg [4];
    logic signed [ACC_W-1:0]   prod_reg [2];
    logic signed [ACC_W-1:0]   acc_reg [2];

    logic [IDX_W-1:0]          self_v [2];
    logic [IDX_W-1:0]          other_v [2];
    logic [WGT_W-1:0]          opa [2];
    logic signed [OPB_W-1:0]   opb [2];
    logic signed [PROD_W-1:0]  prod [2];
    logic signed [ACC_W-1:0]   biased [2];

    assign self_v[0]  = a_val;
    assign other_v[0] = b_val;
    assign self_v[1]  = b_val;
    assign other_v[1] = a_val;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            case (cw.op_a)
                OA_SELF: opa[l] = WGT_W'(self_v[l]);
                OA_TEMP: opa[l] = WGT_W'(temp_reg[l]);
                OA_W0:   opa[l] = w_reg[0];
                OA_W1:   opa[l] = w_reg[1];
                OA_W2:   opa[l] = w_reg[2];
                OA_W3:   opa[l] = w_reg[3];
                default: opa[l] = '0;
            endcase
            case (cw.op_b)
                OB_SELF:   opb[l] = OPB_W'(self_v[l]);
                OB_3OTHER: opb[l] = OPB_W'(other_v[l]) + OPB_W'({other_v[l], 1'b0});
                OB_C0:     opb[l] = OPB_W'(coord[l][0]);
                OB_C1:     opb[l] = OPB_W'(coord[l][1]);
                OB_C2:     opb[l] = OPB_W'(coord[l][2]);
                OB_C3:     opb[l] = OPB_W'(coord[l][3]);
                default:   opb[l] = '0;
            endcase
            prod[l] = $signed({1'b0, opa[l]}) * opb[l];
            // Adding divisor minus one to a negative sum makes the shift
            // truncate toward zero.
            biased[l] = acc_reg[l] + (acc_reg[l][ACC_W-1] ? RND_BIAS : '0);
            res[l]    = biased[l][SHIFT+COORD_W-1:SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        case (cw.dst)
            DST_TEMP: begin
                temp_reg[0] <= prod[0][TMP_W-1:0];
                temp_reg[1] <= prod[1][TMP_W-1:0];
            end
            DST_WEND: begin
                w_reg[0] <= prod[0][WGT_W-1:0];
                w_reg[3] <= prod[1][WGT_W-1:0];
            end
            DST_WMID: begin
                w_reg[1] <= prod[0][WGT_W-1:0];
                w_reg[2] <= prod[1][WGT_W-1:0];
            end
            DST_PROD: begin
                prod_reg[0] <= prod[0][ACC_W-1:0];
                prod_reg[1] <= prod[1][ACC_W-1:0];
            end
            default: ;
        endcase
        for (int l = 0; l < 2; l++) begin
            case (cw.acc)
                ACC_LOAD: acc_reg[l] <= prod_reg[l];
                ACC_ADD:  acc_reg[l] <= acc_reg[l] + prod_reg[l];
                default:  ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/cubic_bezier_segment_generator_top.sv =====
// Top level of the cubic Bezier segment generator: configuration registers,
// step index, handshakes and output register. Uses cbsg_pkg, cbsg_sequencer
// and cbsg_datapath.
//
//   Channel   Direction  Handshake              Contents
//   s_        in         s_valid / s_ready      restart
//   m_        out        m_valid / m_ready      from_x, from_y, to_x, to_y, last
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item is accepted in the idle step and then runs through nine microcode
// steps, set by the single multiplier per coordinate that builds the four
// weights and then accumulates the four weighted control points.
// The output register lets the finished result wait while the next item is
// accepted; the emit step holds only if the previous result is still unread.
// Reset clears the configuration, step index and previous point; no clearing pass.
module cubic_bezier_segment_generator_top import cbsg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_restart,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_from_x,
    output logic signed [COORD_W-1:0] m_from_y,
    output logic signed [COORD_W-1:0] m_to_x,
    output logic signed [COORD_W-1:0] m_to_y,
    output logic                      m_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    logic signed [COORD_W-1:0] cfg_reg [NUM_CFG];
    logic [IDX_W-1:0]          step_reg;
    logic [IDX_W-1:0]          step_next;
    logic [IDX_W-1:0]          cur_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [COORD_W-1:0] from_x_reg;
    logic signed [COORD_W-1:0] from_y_reg;
    logic signed [COORD_W-1:0] to_x_reg;
    logic signed [COORD_W-1:0] to_y_reg;
    logic                      last_reg;

    ucw_t                      cw;
    seq_stat_t                 stat;
    logic                      s_fire;
    logic                      out_busy;
    logic [IDX_W-1:0]          take_idx;
    logic [IDX_W-1:0]          a_val;
    logic signed [COORD_W-1:0] coord [2][4];
    logic signed [COORD_W-1:0] res [2];
    logic                      at_start;
    logic                      at_end;

    assign cfg_ready = 1'b1;
    assign s_ready   = stat.ready;
    assign s_fire    = s_valid & stat.ready;
    assign out_busy  = m_valid_reg & ~m_ready;

    assign coord[0][0] = cfg_reg[CFG_P0_X];
    assign coord[0][1] = cfg_reg[CFG_P1_X];
    assign coord[0][2] = cfg_reg[CFG_P2_X];
    assign coord[0][3] = cfg_reg[CFG_P3_X];
    assign coord[1][0] = cfg_reg[CFG_P0_Y];
    assign coord[1][1] = cfg_reg[CFG_P1_Y];
    assign coord[1][2] = cfg_reg[CFG_P2_Y];
    assign coord[1][3] = cfg_reg[CFG_P3_Y];

    assign take_idx = s_restart ? '0 : step_reg;
    assign a_val    = IDX_W'(STEPS) - cur_reg;
    assign at_start = (cur_reg == '0);
    assign at_end   = (cur_reg == IDX_W'(STEPS));

    always_comb begin
        step_next = step_reg;
        if (s_fire) begin
            step_next = (take_idx == IDX_W'(STEPS)) ? '0 : take_idx + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (stat.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    cbsg_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .cw       (cw),
        .stat     (stat)
    );

    cbsg_datapath u_dp (
        .aclk  (aclk),
        .cw    (cw),
        .a_val (a_val),
        .b_val (cur_reg),
        .coord (coord),
        .res   (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                cfg_reg[k] <= '0;
            end
            step_reg    <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
                cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
            end
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (stat.emit) begin
                prev_x_reg <= res[0];
                prev_y_reg <= res[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg <= take_idx;
        end
        if (stat.emit) begin
            // A pass starts from the configured P0, not from the stored point.
            from_x_reg <= at_start ? cfg_reg[CFG_P0_X] : prev_x_reg;
            from_y_reg <= at_start ? cfg_reg[CFG_P0_Y] : prev_y_reg;
            to_x_reg   <= res[0];
            to_y_reg   <= res[1];
            last_reg   <= at_end;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_from_x = from_x_reg;
    assign m_from_y = from_y_reg;
    assign m_to_x   = to_x_reg;
    assign m_to_y   = to_y_reg;
    assign m_last   = last_reg;

endmodule

// ===== hw/rtl/cbsg_checker.sv =====
// Port-level checks for the cubic Bezier segment generator, bound to the top
// level. Depends on cbsg_pkg and cubic_bezier_segment_generator_top.
module cbsg_port_checks import cbsg_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_from_x,
    input logic signed [COORD_W-1:0] m_from_y,
    input logic signed [COORD_W-1:0] m_to_x,
    input logic signed [COORD_W-1:0] m_to_y,
    input logic                      m_last
);

    // Only one item is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another item is in work");

    // A new result appears only at the end of an item's computation.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared with no item in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_from_x) && $stable(m_from_y)
            && $stable(m_to_x) && $stable(m_to_y) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind cubic_bezier_segment_generator_top cbsg_port_checks u_cbsg_checker (.*);

// ===== bench/cbsg_checker.sv =====
// Checker for the cubic Bezier segment generator: watches the tick, segment and
// register-write channels, predicts every segment and compares it field by field.
// Depends on cbsg_pkg for widths, step count and register indexes.
module cbsg_checker import cbsg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_restart,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [COORD_W-1:0] m_from_x,
    input  logic signed [COORD_W-1:0] m_from_y,
    input  logic signed [COORD_W-1:0] m_to_x,
    input  logic signed [COORD_W-1:0] m_to_y,
    input  logic                      m_last,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    output int                        mismatch_count,
    output int                        pending_segs,
    output int                        segments_seen,
    output int                        passes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic                      last;
    } segment_t;

    logic signed [COORD_W-1:0] ctrl_pt [NUM_CFG];
    logic [IDX_W-1:0]          step_idx;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    segment_t                  expected_segs [$];

    // Exact Bernstein sum over the four control coordinates, divided by
    // STEPS cubed with truncation toward zero.
    function automatic logic signed [COORD_W-1:0] bezier_coord(
        input longint                    t,
        input logic signed [COORD_W-1:0] c0,
        input logic signed [COORD_W-1:0] c1,
        input logic signed [COORD_W-1:0] c2,
        input logic signed [COORD_W-1:0] c3
    );
        longint a;
        longint den;
        longint num;
        a   = longint'(STEPS) - t;
        den = longint'(STEPS) * STEPS * STEPS;
        num = a * a * a * c0 + 3 * a * a * t * c1
            + 3 * a * t * t * c2 + t * t * t * c3;
        return COORD_W'(num / den);
    endfunction

    // Advances the curve by one tick and returns the segment it produces.
    function automatic segment_t advance_curve(input logic restart);
        segment_t seg;
        if (restart || step_idx > STEPS) begin
            step_idx = '0;
        end
        if (step_idx == 0) begin
            seg.from_x = ctrl_pt[CFG_P0_X];
            seg.from_y = ctrl_pt[CFG_P0_Y];
        end else begin
            seg.from_x = curve_x;
            seg.from_y = curve_y;
        end
        seg.to_x = bezier_coord(longint'(step_idx), ctrl_pt[CFG_P0_X], ctrl_pt[CFG_P1_X],
                                ctrl_pt[CFG_P2_X], ctrl_pt[CFG_P3_X]);
        seg.to_y = bezier_coord(longint'(step_idx), ctrl_pt[CFG_P0_Y], ctrl_pt[CFG_P1_Y],
                                ctrl_pt[CFG_P2_Y], ctrl_pt[CFG_P3_Y]);
        seg.last = (step_idx == STEPS);
        curve_x  = seg.to_x;
        curve_y  = seg.to_y;
        step_idx = seg.last ? '0 : step_idx + 1'b1;
        return seg;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: segment %0d field %s expected %0d, got %0d",
                     $realtime, segments_seen, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        segment_t want;
        if (!aresetn) begin
            foreach (ctrl_pt[k]) begin
                ctrl_pt[k] = '0;
            end
            step_idx = '0;
            curve_x  = '0;
            curve_y  = '0;
            expected_segs.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_segs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no segment, got (%0d,%0d)->(%0d,%0d) last %0d",
                             $realtime, m_from_x, m_from_y, m_to_x, m_to_y, m_last);
                end else begin
                    want = expected_segs.pop_front();
                    check_field("from_x", want.from_x, m_from_x);
                    check_field("from_y", want.from_y, m_from_y);
                    check_field("to_x", want.to_x, m_to_x);
                    check_field("to_y", want.to_y, m_to_y);
                    check_field("last", want.last, m_last);
                end
                segments_seen++;
                if (m_last) begin
                    passes_seen++;
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < NUM_CFG) begin
                ctrl_pt[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
            end
            if (s_valid && s_ready) begin
                expected_segs.push_back(advance_curve(s_restart));
            end
        end
        pending_segs = expected_segs.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the cubic Bezier segment generator bench: clock, reset, tick and
// register-write stimulus, output back-pressure, watchdog and verdict.
// Depends on cbsg_pkg, cbsg_checker and cubic_bezier_segment_generator_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbsg_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PASS_TICKS   = STEPS + 1;

    typedef enum {SHAPE_RANDOM, SHAPE_HIGH, SHAPE_LOW, SHAPE_CORNERS} shape_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_restart;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_from_x;
    logic signed [COORD_W-1:0] m_from_y;
    logic signed [COORD_W-1:0] m_to_x;
    logic signed [COORD_W-1:0] m_to_y;
    logic                      m_last;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [COORD_W-1:0]        cfg_data;

    int mismatch_count;
    int pending_segs;
    int segments_seen;
    int passes_seen;
    int ticks_sent;
    int settings_done;
    int quiet_cycles;
    bit gaps_on;
    bit stalls_on;

    cubic_bezier_segment_generator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_from_x  (m_from_x),
        .m_from_y  (m_from_y),
        .m_to_x    (m_to_x),
        .m_to_y    (m_to_y),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbsg_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_from_x       (m_from_x),
        .m_from_y       (m_from_y),
        .m_to_x         (m_to_x),
        .m_to_y         (m_to_y),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_segs   (pending_segs),
        .segments_seen  (segments_seen),
        .passes_seen    (passes_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= !stalls_on || ($urandom_range(0, 99) >= 15);
    end

    // Any accepted item on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("cubic_bezier_segment_generator_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_tick(input logic restart);
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    task automatic hold_input();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending_segs != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(negedge aclk);
        settings_done++;
    endtask

    // Rewrites all four control points while nothing is in flight, plus one
    // write to an unused index that must leave them alone.
    task automatic load_curve(input shape_t shape);
        logic [COORD_W-1:0] val;
        hold_input();
        drain();
        for (int k = 0; k < NUM_CFG; k++) begin
            case (shape)
                SHAPE_HIGH:    val = {1'b0, {(COORD_W-1){1'b1}}};
                SHAPE_LOW:     val = {1'b1, {(COORD_W-1){1'b0}}};
                SHAPE_CORNERS: val = $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                          : {1'b1, {(COORD_W-1){1'b0}}};
                default:       val = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            endcase
            write_reg(CFG_IDX_W'(k), val);
        end
        write_reg(CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)),
                  COORD_W'($urandom_range(0, (1 << COORD_W) - 1)));
        end_writes();
    endtask

    initial begin
        s_valid   = 1'b0;
        s_restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        aresetn   = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Reset state: every control point at zero.
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);

        // Control points at opposite extremes, with restarts early, mid-pass
        // and back to back. Unused indexes are written with all ones and more.
        hold_input();
        drain();
        write_reg(CFG_IDX_W'(CFG_P0_X), 12'h800);
        write_reg(CFG_IDX_W'(CFG_P0_Y), 12'h7FF);
        write_reg(CFG_IDX_W'(CFG_P1_X), 12'h7FF);
        write_reg(CFG_IDX_W'(CFG_P1_Y), 12'h800);
        write_reg(CFG_IDX_W'(CFG_P2_X), 12'h800);
        write_reg(CFG_IDX_W'(CFG_P2_Y), 12'h7FF);
        write_reg(CFG_IDX_W'(CFG_P3_X), 12'h7FF);
        write_reg(CFG_IDX_W'(CFG_P3_Y), 12'h800);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 12'hFFF);
        write_reg(CFG_IDX_W'(NUM_CFG), 12'h5A5);
        end_writes();
        push_tick(1'b1);
        repeat (9) push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        repeat (4) push_tick(1'b0);

        // One whole pass through the last segment and the wrap, with a drain
        // partway, a change of control points mid-pass and a stretch at full rate.
        load_curve(SHAPE_RANDOM);
        push_tick(1'b1);
        for (int k = 1; k < PASS_TICKS + 35; k++) begin
            if (k == 300) begin
                hold_input();
                drain();
            end
            if (k == 600) begin
                load_curve(SHAPE_RANDOM);
            end
            gaps_on   = !(k >= 700 && k < 900);
            stalls_on = gaps_on;
            push_tick(1'b0);
        end

        // Short runs under every shape of control points with occasional restarts.
        for (int p = 0; p < 8; p++) begin
            load_curve(shape_t'(p % 4));
            repeat (64) push_tick($urandom_range(0, 99) < 5);
        end

        hold_input();
        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run sent %0d ticks under %0d control point settings, extremes included.",
                 ticks_sent, settings_done);
        $display("Compared %0d segments, %0d of them ending a pass at t = 1.",
                 segments_seen, passes_seen);
        if (mismatch_count == 0) begin
            $display("cubic_bezier_segment_generator_top test passed");
        end else begin
            $display("cubic_bezier_segment_generator_top test failed");
        end
        $finish;
    end

endmodule
